// ----- hw/rtl/wske_pkg.sv -----
// ----------------------------------------------------------------------------
// wske_pkg: shared types and constants
// Field widths, register map, payload structs and the job descriptor that
// passes from the front part to the back part of the slope estimator.
// ----------------------------------------------------------------------------
package wske_pkg;

    localparam int PHI_W       = 20;
    localparam int KDP_W       = 20;
    localparam int WLEN_W      = 5;
    localparam int GSIZE_W     = 13;
    localparam int CNT_W       = 5;
    localparam int MAX_WINDOW_DEF = 25;
    localparam int PADDR_W     = 3;

    localparam logic [CNT_W-1:0]   SEEN_CAP  = 5'd31;
    localparam logic [WLEN_W-1:0]  WLEN_RST  = 5'd9;
    localparam logic [GSIZE_W-1:0] GSIZE_RST = 13'd256;
    localparam logic [WLEN_W-1:0]  WLEN_MIN  = 5'd5;

    localparam logic signed [KDP_W-1:0] KDP_MAX = 20'sd524287;
    localparam logic signed [KDP_W-1:0] KDP_MIN = -20'sd524288;

    localparam logic REG_WINDOW_LEN = 1'b0;
    localparam logic REG_GATE_SIZE  = 1'b1;

    typedef struct packed {
        logic signed [PHI_W-1:0] phi;
        logic                    last_gate;
    } in_t;

    typedef struct packed {
        logic signed [KDP_W-1:0] kdp;
        logic                    no_data;
        logic                    last_out;
    } out_t;

    typedef struct packed {
        logic [CNT_W-1:0] p;
        logic [CNT_W-1:0] hw;
        logic [CNT_W-1:0] received;
        logic             last_out;
    } job_t;

    typedef struct packed {
        logic                    en;
        logic signed [PHI_W-1:0] data;
    } wr_t;

endpackage

// ----- hw/rtl/wske_front.sv -----
// ----------------------------------------------------------------------------
// wske_front: gate intake and job issue
// Accepts gates, tracks the radial counters, writes samples to the window
// store and issues one fit job per result into the job queue.
// ----------------------------------------------------------------------------
module wske_front #(
    parameter int MAX_WINDOW = wske_pkg::MAX_WINDOW_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  wske_pkg::in_t                 in_data,
    input  logic [wske_pkg::WLEN_W-1:0]   window_len,
    input  logic                          back_busy,
    input  logic                          q_full,
    output logic                          q_push,
    output wske_pkg::job_t                q_job,
    output wske_pkg::wr_t                 wr
);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t                       state_reg, state_next;
    logic [wske_pkg::CNT_W-1:0]   seen_reg, seen_next;
    logic [wske_pkg::CNT_W:0]     off_reg, off_next;
    logic [wske_pkg::CNT_W-1:0]   hw_reg, hw_next;
    logic                         last_reg, last_next;
    logic                         accept;
    logic                         bad;
    logic [wske_pkg::CNT_W:0]     thr;
    logic                         more;

    assign in_stall = (state_reg != ST_IDLE) || back_busy;
    assign accept   = in_valid && !in_stall;
    assign bad      = (window_len < wske_pkg::WLEN_MIN) || !window_len[0]
                      || (32'(window_len) > 32'(MAX_WINDOW));
    assign thr      = last_reg ? '0 : {1'b0, hw_reg};
    assign more     = off_reg > thr;

    assign wr.en    = accept && !bad;
    assign wr.data  = in_data.phi;

    assign q_push       = (state_reg == ST_EMIT) && more && !q_full;
    assign q_job.p      = wske_pkg::CNT_W'(off_reg - 1'b1);
    assign q_job.hw     = hw_reg;
    assign q_job.received = seen_reg;
    assign q_job.last_out = last_reg && (off_reg == 1);

    always_comb
    begin
        state_next = state_reg;
        seen_next  = seen_reg;
        off_next   = off_reg;
        hw_next    = hw_reg;
        last_next  = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (bad)
                    begin
                        seen_next = '0;
                        off_next  = '0;
                    end
                    else
                    begin
                        if (seen_reg < wske_pkg::SEEN_CAP)
                            seen_next = seen_reg + 1'b1;
                        off_next   = off_reg + 1'b1;
                        hw_next    = window_len >> 1;
                        last_next  = in_data.last_gate;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (more)
                begin
                    if (!q_full)
                        off_next = off_reg - 1'b1;
                end
                else
                begin
                    if (last_reg)
                    begin
                        seen_next = '0;
                        off_next  = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seen_reg  <= '0;
            off_reg   <= '0;
            hw_reg    <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            seen_reg  <= seen_next;
            off_reg   <= off_next;
            hw_reg    <= hw_next;
            last_reg  <= last_next;
        end
    end

endmodule

// ----- hw/rtl/wske_jobq.sv -----
// ----------------------------------------------------------------------------
// wske_jobq: job queue
// Four-entry FIFO of fit jobs between the front and back parts.
// ----------------------------------------------------------------------------
module wske_jobq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  wske_pkg::job_t push_job,
    input  logic           pop,
    output wske_pkg::job_t head,
    output logic           full,
    output logic           empty
);

    wske_pkg::job_t slot_reg [4];
    logic [1:0]     wptr_reg, wptr_next;
    logic [1:0]     rptr_reg, rptr_next;
    logic [2:0]     cnt_reg, cnt_next;
    logic           do_push, do_pop;

    assign full    = cnt_reg == 3'd4;
    assign empty   = cnt_reg == 3'd0;
    assign head    = slot_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wptr_next = do_push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = do_pop ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg + {2'b0, do_push} - {2'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ----- hw/rtl/wske_back.sv -----
// ----------------------------------------------------------------------------
// wske_back: fit engine
// Holds the sample window, runs the weighted sum one tap per cycle, forms
// the denominator, divides with rounding one quotient bit per cycle and
// loads the output register.
// ----------------------------------------------------------------------------
module wske_back #(
    parameter int MAX_WINDOW = wske_pkg::MAX_WINDOW_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  wske_pkg::wr_t                wr,
    input  logic [wske_pkg::GSIZE_W-1:0] gate_size,
    input  logic                         q_empty,
    input  wske_pkg::job_t               q_head,
    output logic                         q_pop,
    output logic                         busy,
    output logic                         out_valid,
    input  logic                         out_stall,
    output wske_pkg::out_t               out_data
);

    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int DEPTH = 1 << AW;
    localparam int M_W   = 6;
    localparam int C_W   = 8;
    localparam int ACC_W = wske_pkg::PHI_W + C_W + M_W;
    localparam int T_W   = 3 * M_W;
    localparam int DEN_W = wske_pkg::GSIZE_W + T_W;
    localparam int QB    = wske_pkg::KDP_W;
    localparam int DIV_W = DEN_W + QB + 2;
    localparam int QC_W  = $clog2(QB);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MAC,
        ST_DRAIN,
        ST_DEN1,
        ST_DEN2,
        ST_DEN3,
        ST_PREP,
        ST_CHECK,
        ST_DIV,
        ST_RES,
        ST_OUT
    } state_t;

    logic signed [wske_pkg::PHI_W-1:0] mem [DEPTH];
    logic [AW-1:0]                 wptr_reg;
    logic signed [wske_pkg::PHI_W-1:0] rd_data_reg;

    state_t                        state_reg;
    wske_pkg::job_t                job_reg;
    logic [M_W-1:0]                m_reg;
    logic [M_W-1:0]                top_reg;
    logic [M_W-1:0]                k_reg;
    logic signed [C_W-1:0]         coef_reg;
    logic                          vld_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic [2*M_W-1:0]              mm1_reg;
    logic [T_W-1:0]                t_reg;
    logic [DEN_W-1:0]              den_reg;
    logic [DIV_W-1:0]              rem_reg;
    logic [DIV_W-1:0]              dsh_reg;
    logic                          neg_reg;
    logic                          sat_reg;
    logic [QB-1:0]                 q_reg;
    logic [QC_W-1:0]               qc_reg;
    logic                          out_valid_reg;
    wske_pkg::out_t                out_reg;
    wske_pkg::out_t                res_reg;

    logic [M_W-1:0]                l_w, r_w, ltmp;
    logic [M_W-1:0]                idx;
    logic [AW-1:0]                 rd_addr;
    logic signed [C_W-1:0]         coef_w;
    logic signed [C_W+wske_pkg::PHI_W-1:0] prod;
    logic signed [ACC_W+1:0]       acc3;
    logic signed [ACC_W+13:0]      num;
    logic [wske_pkg::GSIZE_W-1:0]  g;
    logic                          out_free;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign busy      = (state_reg != ST_IDLE) || !q_empty;
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;

    always_comb
    begin
        if ({1'b0, job_reg.received} > {1'b0, job_reg.p})
            ltmp = M_W'(job_reg.received) - M_W'(job_reg.p) - 1'b1;
        else
            ltmp = '0;
        l_w = (ltmp > M_W'(job_reg.hw)) ? M_W'(job_reg.hw) : ltmp;
        r_w = (job_reg.p < job_reg.hw) ? M_W'(job_reg.p) : M_W'(job_reg.hw);
    end

    assign idx     = top_reg - k_reg;
    assign rd_addr = wptr_reg - AW'(idx);
    assign coef_w  = $signed({1'b0, k_reg, 1'b0}) - $signed({2'b0, m_reg}) + C_W'(1);
    assign prod    = coef_reg * rd_data_reg;
    assign acc3    = (ACC_W+2)'(acc_reg) + ((ACC_W+2)'(acc_reg) <<< 1);
    assign num     = (ACC_W+14)'(acc3) <<< 12;
    assign g       = (gate_size == '0) ? wske_pkg::GSIZE_W'(1) : gate_size;

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wptr_reg + 1'b1] <= wr.data;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        coef_reg <= coef_w;
        if (vld_reg)
            acc_reg <= acc_reg + prod;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                    job_reg <= q_head;
            end
            ST_SETUP:
            begin
                m_reg   <= l_w + r_w + 1'b1;
                top_reg <= M_W'(job_reg.p) + l_w;
                k_reg   <= '0;
                acc_reg <= '0;
                res_reg.kdp      <= '0;
                res_reg.no_data  <= 1'b1;
                res_reg.last_out <= job_reg.last_out;
            end
            ST_MAC:   k_reg   <= k_reg + 1'b1;
            ST_DRAIN: ;
            ST_DEN1:  mm1_reg <= {{M_W{1'b0}}, m_reg} * {{M_W{1'b0}}, m_reg} - 1'b1;
            ST_DEN2:  t_reg   <= {{(T_W-M_W){1'b0}}, m_reg} * {{M_W{1'b0}}, mm1_reg};
            ST_DEN3:
            begin
                den_reg <= {{T_W{1'b0}}, g} * {{wske_pkg::GSIZE_W{1'b0}}, t_reg};
                neg_reg <= num < 0;
                rem_reg <= DIV_W'(num < 0 ? -num : num);
            end
            ST_PREP:
            begin
                rem_reg <= rem_reg + DIV_W'(den_reg >> 1);
                dsh_reg <= DIV_W'(den_reg) << (QB - 1);
            end
            ST_CHECK:
            begin
                sat_reg <= rem_reg >= (DIV_W'(den_reg) << QB);
                q_reg   <= '0;
                qc_reg  <= '0;
            end
            ST_DIV:
            begin
                if (rem_reg >= dsh_reg)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                    q_reg   <= {q_reg[QB-2:0], 1'b1};
                end
                else
                    q_reg   <= {q_reg[QB-2:0], 1'b0};
                dsh_reg <= dsh_reg >> 1;
                qc_reg  <= qc_reg + 1'b1;
            end
            ST_RES:
            begin
                res_reg.no_data <= 1'b0;
                if (neg_reg)
                begin
                    if (sat_reg || q_reg > QB'(524288))
                        res_reg.kdp <= wske_pkg::KDP_MIN;
                    else
                        res_reg.kdp <= -$signed(q_reg);
                end
                else
                begin
                    if (sat_reg || q_reg > QB'(524287))
                        res_reg.kdp <= wske_pkg::KDP_MAX;
                    else
                        res_reg.kdp <= $signed(q_reg);
                end
            end
            ST_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wptr_reg      <= '0;
            vld_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (wr.en)
                wptr_reg <= wptr_reg + 1'b1;
            vld_reg <= state_reg == ST_MAC;
            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= res_reg;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:  if (!q_empty) state_reg <= ST_SETUP;
                ST_SETUP: state_reg <= (l_w + r_w == '0) ? ST_OUT : ST_MAC;
                ST_MAC:   if (k_reg == m_reg - 1'b1) state_reg <= ST_DRAIN;
                ST_DRAIN: state_reg <= ST_DEN1;
                ST_DEN1:  state_reg <= ST_DEN2;
                ST_DEN2:  state_reg <= ST_DEN3;
                ST_DEN3:  state_reg <= ST_PREP;
                ST_PREP:  state_reg <= ST_CHECK;
                ST_CHECK: state_reg <= ST_DIV;
                ST_DIV:   if (qc_reg == QC_W'(QB - 1)) state_reg <= ST_RES;
                ST_RES:   state_reg <= ST_OUT;
                ST_OUT:   if (out_free) state_reg <= ST_IDLE;
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- hw/rtl/windowed_slope_kdp_estimator_top.sv -----
// ----------------------------------------------------------------------------
// windowed_slope_kdp_estimator_top: least-squares slope KDP estimator
// One phase beat per range gate enters on the in channel (valid/stall); one
// KDP beat per gate leaves on the out channel, half a window later, and the
// pending tail of the radial is flushed on the gate marked last_gate.
// Registers window_len (address 0) and gate_size (address 4) sit on the APB
// port; the user writes them only while the block is idle (not enforced).
// A gate is taken only when the fit engine and its job queue are empty. Each
// result reads the m gates of its fit one tap per cycle through the window
// store read port, then runs a 20-step rounding divider. A single-gate fit
// goes straight to the output. A gate that closes the radial costs one such
// pass per pending result.
// Reset clears the radial counters, the queue and the output register and
// loads the register defaults; the sample store is not cleared.
// When the receiver stalls, the output register holds its beat and the
// engine waits; the front, which waits for an idle engine, stops taking gates.
// ----------------------------------------------------------------------------
module windowed_slope_kdp_estimator_top #(
    parameter int MAX_WINDOW = wske_pkg::MAX_WINDOW_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  wske_pkg::in_t                 in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output wske_pkg::out_t                out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wske_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [wske_pkg::WLEN_W-1:0]  wlen_reg;
    logic [wske_pkg::GSIZE_W-1:0] gsize_reg;
    logic                         cfg_wr;
    logic                         q_full, q_empty, q_push, q_pop, back_busy;
    wske_pkg::job_t               q_job, q_head;
    wske_pkg::wr_t                wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == wske_pkg::REG_GATE_SIZE)
                    ? 32'(gsize_reg) : 32'(wlen_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg  <= wske_pkg::WLEN_RST;
            gsize_reg <= wske_pkg::GSIZE_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == wske_pkg::REG_WINDOW_LEN)
                wlen_reg  <= pwdata[wske_pkg::WLEN_W-1:0];
            else
                gsize_reg <= pwdata[wske_pkg::GSIZE_W-1:0];
        end
    end

    wske_front #(.MAX_WINDOW(MAX_WINDOW)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .window_len (wlen_reg),
        .back_busy  (back_busy),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (q_job),
        .wr         (wr)
    );

    wske_jobq u_jobq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    wske_back #(.MAX_WINDOW(MAX_WINDOW)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .gate_size (gsize_reg),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .busy      (back_busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ----- dv/wske_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wske_checker: scoreboard for the slope KDP estimator
// Watches the APB port, the phase channel and the KDP channel. Keeps its own
// copy of the registers, the sample store and the radial counters, computes
// the least-squares slope for every gate that becomes due and compares each
// KDP beat with the oldest due result.
// ----------------------------------------------------------------------------
module wske_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  wske_pkg::in_t                  in_data,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  wske_pkg::out_t                 out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [wske_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output int                             fails,
    output int                             due_count
);

    logic [wske_pkg::WLEN_W-1:0]       wlen;
    logic [wske_pkg::GSIZE_W-1:0]      gsize;
    logic signed [wske_pkg::PHI_W-1:0] phase_hist [wske_pkg::MAX_WINDOW_DEF];
    int                                gates_rcvd;
    int                                unanswered;
    wske_pkg::out_t                    due_kdp [$];

    function automatic wske_pkg::out_t slope_fit(int p, int hw, int rcvd);
        wske_pkg::out_t res;
        int      r;
        int      l;
        int      m;
        longint  s2;
        longint  x;
        longint  num;
        longint  den;
        longint  mag;
        longint  q;
        longint  g;
        int      idx;
        res = '0;
        r = (p < hw) ? p : hw;
        l = (rcvd > p) ? rcvd - 1 - p : 0;
        if (l > hw)
            l = hw;
        m = l + r + 1;
        if (m <= 1)
        begin
            res.no_data = 1'b1;
            return res;
        end
        s2 = 0;
        for (int k = 0; k < m; k++)
        begin
            idx = p + l - k;
            x = (idx < wske_pkg::MAX_WINDOW_DEF) ? longint'(phase_hist[idx]) : 0;
            s2 += longint'(2 * k - (m - 1)) * x;
        end
        g = (gsize == 0) ? 1 : longint'(gsize);
        den = g * m * (longint'(m) * m - 1);
        num = s2 * 3 * 4096;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        if (num < 0)
            res.kdp = (q > 524288) ? wske_pkg::KDP_MIN : wske_pkg::KDP_W'(-q);
        else
            res.kdp = (q > 524287) ? wske_pkg::KDP_MAX : wske_pkg::KDP_W'(q);
        return res;
    endfunction

    task automatic predict_gate(wske_pkg::in_t g);
        int             hw;
        int             p;
        wske_pkg::out_t res;
        if (wlen < wske_pkg::WLEN_MIN || !wlen[0] || wlen > wske_pkg::MAX_WINDOW_DEF)
        begin
            gates_rcvd = 0;
            unanswered = 0;
            return;
        end
        hw = wlen / 2;
        for (int i = wske_pkg::MAX_WINDOW_DEF - 1; i > 0; i--)
            phase_hist[i] = phase_hist[i-1];
        phase_hist[0] = g.phi;
        if (gates_rcvd < wske_pkg::SEEN_CAP)
            gates_rcvd++;
        unanswered++;
        while (unanswered > (g.last_gate ? 0 : hw))
        begin
            p = unanswered - 1;
            res = slope_fit(p, hw, gates_rcvd);
            res.last_out = g.last_gate && p == 0;
            due_kdp.push_back(res);
            unanswered--;
        end
        if (g.last_gate)
        begin
            gates_rcvd = 0;
            unanswered = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        wske_pkg::out_t want;
        if (!rst_n)
        begin
            wlen = wske_pkg::WLEN_RST;
            gsize = wske_pkg::GSIZE_RST;
            gates_rcvd = 0;
            unanswered = 0;
            fails = 0;
            due_kdp.delete();
            due_count = 0;
            for (int i = 0; i < wske_pkg::MAX_WINDOW_DEF; i++)
                phase_hist[i] = '0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_kdp.size() == 0)
                begin
                    $error("unexpected kdp beat %h", out_data);
                    fails++;
                end
                else
                begin
                    want = due_kdp.pop_front();
                    if (out_data.kdp !== want.kdp)
                    begin
                        $error("kdp: expected %0d, got %0d", want.kdp, out_data.kdp);
                        fails++;
                    end
                    if (out_data.no_data !== want.no_data)
                    begin
                        $error("no_data: expected %0b, got %0b", want.no_data,
                               out_data.no_data);
                        fails++;
                    end
                    if (out_data.last_out !== want.last_out)
                    begin
                        $error("last_out: expected %0b, got %0b", want.last_out,
                               out_data.last_out);
                        fails++;
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_gate(in_data);
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == wske_pkg::REG_GATE_SIZE)
                    gsize = pwdata[wske_pkg::GSIZE_W-1:0];
                else
                    wlen = pwdata[wske_pkg::WLEN_W-1:0];
            end
            due_count = due_kdp.size();
        end
    end

endmodule

// ----- dv/windowed_slope_kdp_estimator_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windowed_slope_kdp_estimator_top_tb: testbench for the slope KDP estimator
// Drives radials of phase gates in random bursts under a varying receiver
// stall pattern, reprograms window length and gate size between phases
// (legal, illegal and extreme values, also in the middle of a radial) and
// lets the checker compare every KDP beat with its own prediction.
// ----------------------------------------------------------------------------
module windowed_slope_kdp_estimator_top_tb;

    localparam logic [wske_pkg::PADDR_W-1:0] ADDR_WINDOW_LEN =
        {wske_pkg::REG_WINDOW_LEN, 2'b00};
    localparam logic [wske_pkg::PADDR_W-1:0] ADDR_GATE_SIZE  =
        {wske_pkg::REG_GATE_SIZE, 2'b00};
    localparam int STALL_LIMIT = 20000;
    localparam int TARGET_GATES = 300;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    wske_pkg::in_t                in_data = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    wske_pkg::out_t               out_data;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [wske_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0]                  pwdata = '0;
    logic [31:0]                  prdata;
    logic                         pready;
    int                           fails;
    int                           due_count;
    int                           burst_left = 0;
    int                           gates_sent = 0;
    int                           idle_cycles = 0;
    int                           cyc = 0;

    always #5 clk = ~clk;

    windowed_slope_kdp_estimator_top DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    wske_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .fails(fails), .due_count(due_count)
    );

    always @(negedge clk)
    begin
        cyc <= cyc + 1;
        case ((cyc / 400) % 3)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(2) == 0);
            default: out_stall <= ((cyc % 9) < 4);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic reg_write(logic [wske_pkg::PADDR_W-1:0] addr, logic [31:0] data);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_gate(logic [wske_pkg::PHI_W-1:0] phi, logic last);
        in_valid <= 1'b1;
        in_data <= '{phi: phi, last_gate: last};
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        gates_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(negedge clk);
            burst_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(30);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (due_count != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic send_radial(int len, bit close);
        int  shape;
        int  base;
        int  slope;
        int  noise;
        int  v;
        shape = $urandom_range(3);
        base = $urandom_range(400000) - 200000;
        slope = $urandom_range(6000) - 3000;
        noise = $urandom_range(2000);
        for (int k = 0; k < len; k++)
        begin
            if (shape == 0)
                v = $urandom;
            else
                v = base + slope * k + $urandom_range(2 * noise) - noise;
            send_gate(wske_pkg::PHI_W'(v), close && k == len - 1);
        end
    endtask

    initial
    begin
        int wl;
        int gs;
        int left;
        int len;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        send_gate('0, 1'b1);
        send_gate(20'sd1000, 1'b0);
        send_gate(-20'sd1000, 1'b1);
        for (int k = 0; k < 10; k++)
            send_gate((k % 2) ? wske_pkg::KDP_MIN : wske_pkg::KDP_MAX, k == 9);
        settle();
        reg_write(ADDR_GATE_SIZE, 32'd1);
        for (int k = 0; k < 7; k++)
            send_gate((k < 3) ? wske_pkg::KDP_MIN : wske_pkg::KDP_MAX, k == 6);
        settle();

        for (int ph = 0; gates_sent < TARGET_GATES; ph++)
        begin
            case (ph)
                0: begin wl = 5; gs = 8191; end
                1: begin wl = 25; gs = 0; end
                2: begin wl = 31; gs = 4096; end
                3: begin wl = 0; gs = 1; end
                4: begin wl = 6; gs = 256; end
                default:
                begin
                    wl = ($urandom_range(5) == 0) ? $urandom_range(31)
                                                  : 2 * $urandom_range(12, 2) + 1;
                    gs = ($urandom_range(3) == 0) ? $urandom_range(8191)
                                                  : $urandom_range(4096, 1);
                end
            endcase
            reg_write(ADDR_WINDOW_LEN, 32'(wl));
            reg_write(ADDR_GATE_SIZE, 32'(gs));
            if (wl < wske_pkg::WLEN_MIN || wl % 2 == 0 || wl > wske_pkg::MAX_WINDOW_DEF)
                send_radial(4, 1'b1);
            else
            begin
                left = 25;
                while (left > 0)
                begin
                    len = ($urandom_range(5) == 0) ? 1 : $urandom_range(40, 2);
                    send_radial(len, !(len >= left && $urandom_range(1)));
                    left -= len;
                end
            end
            settle();
        end

        settle();
        if (fails == 0 && due_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/wske_pkg.sv
hw/rtl/wske_front.sv
hw/rtl/wske_jobq.sv
hw/rtl/wske_back.sv
hw/rtl/windowed_slope_kdp_estimator_top.sv
dv/wske_checker.sv
dv/windowed_slope_kdp_estimator_top_tb.sv
